// File: hdl/sts_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sts_pkg
// Types and constants shared by the sector transfer splitter modules.
// ----------------------------------------------------------------------------
package sts_pkg;

  // field widths
  localparam int BYTE_W    = 60;  // byte offsets and counts
  localparam int DIV_W     = 61;  // request end position, divider dividend
  localparam int SB_W      = 13;  // sector size register
  localparam int REM_W     = 12;  // remainder, offset inside a sector
  localparam int DSEC_W    = 49;  // absolute disk sector
  localparam int TOTAL_W   = 48;  // sectors in a run
  localparam int CFG_IDX_W = 2;

  // one restoring step per cell, one cell per quotient bit
  localparam int NUM_CELLS = DIV_W;
  // pieces per request
  localparam int NUM_SLOTS = 3;

  localparam logic [SB_W-1:0] SB_RESET = 13'd512;
  localparam logic [SB_W-1:0] SB_MAX   = 13'd4096;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_VOLUME_START   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_VOLUME_SECTORS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SECTOR_BYTES   = 2'd2;

  typedef enum logic [1:0] {
    PIECE_PARTIAL = 2'd0,
    PIECE_FULL    = 2'd1,
    PIECE_ERROR   = 2'd2
  } piece_kind_e;

  typedef struct packed {
    logic              action;
    logic [BYTE_W-1:0] byte_offset;
    logic [BYTE_W-1:0] byte_count;
  } req_t;

  typedef struct packed {
    piece_kind_e        piece_kind;
    logic               is_write;
    logic [DSEC_W-1:0]  disk_sector;
    logic [TOTAL_W-1:0] sector_total;
    logic [REM_W-1:0]   offset_in_sector;
    logic [SB_W-1:0]    piece_bytes;
    logic [BYTE_W-1:0]  buffer_offset;
    logic               last;
  } res_t;

  // one division lane: partial remainder and dividend/quotient shift word
  typedef struct packed {
    logic [REM_W-1:0] rem;
    logic [DIV_W-1:0] dq;
  } div_lane_t;

  // what travels from cell to cell
  typedef struct packed {
    logic              wr;
    logic              err;
    logic [BYTE_W-1:0] cnt;
    div_lane_t         off_l;
    div_lane_t         end_l;
  } div_t;

endpackage

// File: hdl/sector_transfer_splitter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sector_transfer_splitter
// Splits a byte-granular volume request into head, full-run and tail disk
// commands, or one error piece, through a chain of divider cells.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; busy then stays high
// so that the result port can carry up to three pieces, one piece per cycle,
// before the next request can enter. Each request passes through one entry
// register, 61 divider cells (one quotient bit each, shared by the start and
// end positions), a decode register, the piece slots and the output register.
// A piece that does not exist leaves an idle cycle in its place. Each result
// is shown for one cycle with res_valid_o and the receiver cannot hold it
// off. Configuration writes belong to idle periods only.
module sector_transfer_splitter import sts_pkg::*; #(
  parameter int SECTOR_ADDR_BITS = 48
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  req_t                        req_i,
  input  logic                        cfg_we_i,
  input  logic [CFG_IDX_W-1:0]        cfg_idx_i,
  input  logic [SECTOR_ADDR_BITS-1:0] cfg_data_i,
  output logic                        res_valid_o,
  output res_t                        res_o
);

  localparam int PROD_W = SECTOR_ADDR_BITS + SB_W;
  localparam int CMP_W  = 64;
  localparam int LIM_W  = (PROD_W > CMP_W) ? CMP_W : PROD_W;

  // configuration registers
  logic [SECTOR_ADDR_BITS-1:0] vstart_q, vsect_q;
  logic [SB_W-1:0]             sb_q, sb_eff;
  logic [PROD_W-1:0]           prod;
  logic [LIM_W-1:0]            limit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vstart_q <= '0;
      vsect_q  <= '0;
      sb_q     <= SB_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_VOLUME_START:   vstart_q <= cfg_data_i;
        CFG_VOLUME_SECTORS: vsect_q  <= cfg_data_i;
        CFG_SECTOR_BYTES:   sb_q     <= cfg_data_i[SB_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    priority if (sb_q == '0) begin
      sb_eff = SB_W'(1);
    end else if (sb_q > SB_MAX) begin
      sb_eff = SB_MAX;
    end else begin
      sb_eff = sb_q;
    end
  end

  // volume size in bytes, the full 61-bit product, which cannot wrap
  assign prod = PROD_W'(vsect_q) * PROD_W'(sb_eff);

  always_ff @(posedge clk_i) begin
    limit_q <= prod[LIM_W-1:0];
  end

  // request acceptance, held off while busy
  logic       accept;
  logic [1:0] gap_q;

  assign accept = start & ~busy;
  assign busy   = (gap_q != '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gap_q <= '0;
    end else if (accept) begin
      gap_q <= 2'(NUM_SLOTS - 1);
    end else if (gap_q != '0) begin
      gap_q <= gap_q - 2'd1;
    end
  end

  // entry register
  logic              ent_v_q, ent_wr_q;
  logic [BYTE_W-1:0] ent_off_q, ent_cnt_q;
  logic [DIV_W-1:0]  ent_end_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ent_v_q <= 1'b0;
    end else begin
      ent_v_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      ent_wr_q  <= ~req_i.action;
      ent_off_q <= req_i.byte_offset;
      ent_cnt_q <= req_i.byte_count;
      ent_end_q <= DIV_W'(req_i.byte_offset) + DIV_W'(req_i.byte_count);
    end
  end

  // divider chain
  logic chain_v [NUM_CELLS+1];
  div_t chain_d [NUM_CELLS+1];

  always_comb begin
    chain_v[0]           = ent_v_q;
    chain_d[0].wr        = ent_wr_q;
    chain_d[0].err       = CMP_W'(ent_end_q) > CMP_W'(limit_q);
    chain_d[0].cnt       = ent_cnt_q;
    chain_d[0].off_l.rem = '0;
    chain_d[0].off_l.dq  = DIV_W'(ent_off_q);
    chain_d[0].end_l.rem = '0;
    chain_d[0].end_l.dq  = ent_end_q;
  end

  for (genvar k = 0; k < NUM_CELLS; k++) begin : g_cell
    sts_div_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .sb_i    (sb_eff),
      .valid_i (chain_v[k]),
      .data_i  (chain_d[k]),
      .valid_o (chain_v[k+1]),
      .data_o  (chain_d[k+1])
    );
  end

  // piece decode and output
  logic                 load;
  logic [NUM_SLOTS-1:0] slot_v;
  res_t                 slot [NUM_SLOTS];

  sts_piece_build #(
    .SECTOR_ADDR_BITS (SECTOR_ADDR_BITS)
  ) u_build (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .sb_i     (sb_eff),
    .base_i   (vstart_q),
    .valid_i  (chain_v[NUM_CELLS]),
    .data_i   (chain_d[NUM_CELLS]),
    .load_o   (load),
    .slot_v_o (slot_v),
    .slot_o   (slot)
  );

  sts_emit u_emit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (load),
    .slot_v_i    (slot_v),
    .slot_i      (slot),
    .res_valid_o (res_valid_o),
    .res_o       (res_o)
  );

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("busy not raised after a transfer");

  // busy covers the output slots needed for the remaining pieces
  a_busy_span: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> $past(busy, 2))
    else $error("busy dropped too early");
`endif

endmodule

// File: hdl/sts_div_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sts_div_cell
// One divider cell: a restoring step on the start and end positions of a
// request, giving one quotient bit each, then hands the item to the next cell.
// ----------------------------------------------------------------------------
module sts_div_cell import sts_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic [SB_W-1:0] sb_i,
  input  logic            valid_i,
  input  div_t            data_i,
  output logic            valid_o,
  output div_t            data_o
);

  function automatic div_lane_t div_step(div_lane_t lane, logic [SB_W-1:0] sb);
    div_lane_t       res;
    logic [SB_W-1:0] t;
    logic            q;
    t = {lane.rem, lane.dq[DIV_W-1]};
    q = (t >= sb);
    if (q) begin
      t = t - sb;
    end
    res.rem = t[REM_W-1:0];
    res.dq  = {lane.dq[DIV_W-2:0], q};
    return res;
  endfunction

  logic valid_q;
  div_t data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q.wr    <= data_i.wr;
    data_q.err   <= data_i.err;
    data_q.cnt   <= data_i.cnt;
    data_q.off_l <= div_step(data_i.off_l, sb_i);
    data_q.end_l <= div_step(data_i.end_l, sb_i);
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// File: hdl/sts_piece_build.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sts_piece_build
// Turns quotients and remainders into up to three disk commands: partial
// head, run of whole sectors, partial tail, or a single error piece.
// ----------------------------------------------------------------------------
module sts_piece_build import sts_pkg::*; #(
  parameter int SECTOR_ADDR_BITS = 48
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [SB_W-1:0]             sb_i,
  input  logic [SECTOR_ADDR_BITS-1:0] base_i,
  input  logic                        valid_i,
  input  div_t                        data_i,
  output logic                        load_o,
  output logic [NUM_SLOTS-1:0]        slot_v_o,
  output res_t                        slot_o [NUM_SLOTS]
);

  typedef struct packed {
    logic               wr;
    logic               err;
    logic               zero;
    logic               single;
    logic               head_mis;
    logic               tail_mis;
    logic               has_full;
    logic [DSEC_W-1:0]  first;
    logic [DSEC_W-1:0]  aligned;
    logic [DSEC_W-1:0]  last_sec;
    logic [TOTAL_W-1:0] full;
    logic [REM_W-1:0]   r_off;
    logic [REM_W-1:0]   r_end;
    logic [SB_W-1:0]    head_bytes;
    logic [BYTE_W-1:0]  cnt;
  } pre_t;

  logic             head_mis, tail_mis;
  logic [DIV_W-1:0] aligned, full_w;
  pre_t             pre_d, pre_q;
  logic             pre_v_q;

  // first sector boundary at or after the start
  assign head_mis = |data_i.off_l.rem;
  assign tail_mis = |data_i.end_l.rem;
  assign aligned  = data_i.off_l.dq + DIV_W'(head_mis);
  assign full_w   = data_i.end_l.dq - aligned;

  always_comb begin
    pre_d.wr         = data_i.wr;
    pre_d.err        = data_i.err;
    pre_d.zero       = (data_i.cnt == '0);
    pre_d.single     = head_mis & tail_mis & (data_i.off_l.dq == data_i.end_l.dq);
    pre_d.head_mis   = head_mis;
    pre_d.tail_mis   = tail_mis;
    pre_d.has_full   = (data_i.end_l.dq > aligned);
    pre_d.first      = data_i.off_l.dq[DSEC_W-1:0];
    pre_d.aligned    = aligned[DSEC_W-1:0];
    pre_d.last_sec   = data_i.end_l.dq[DSEC_W-1:0];
    pre_d.full       = full_w[TOTAL_W-1:0];
    pre_d.r_off      = data_i.off_l.rem;
    pre_d.r_end      = data_i.end_l.rem;
    pre_d.head_bytes = head_mis ? (sb_i - {1'b0, data_i.off_l.rem}) : '0;
    pre_d.cnt        = data_i.cnt;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pre_v_q <= 1'b0;
    end else begin
      pre_v_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    pre_q <= pre_d;
  end

  logic [DSEC_W-1:0] base_w, sec_head, sec_full, sec_tail;

  assign base_w   = DSEC_W'(base_i);
  assign sec_head = base_w + pre_q.first;
  assign sec_full = base_w + pre_q.aligned;
  assign sec_tail = base_w + pre_q.last_sec;

  always_comb begin
    slot_v_o = '0;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      slot_o[i] = '0;
      slot_o[i].is_write = pre_q.wr;
    end
    priority if (pre_q.err) begin
      slot_v_o[0]         = 1'b1;
      slot_o[0].piece_kind = PIECE_ERROR;
      slot_o[0].last       = 1'b1;
    end else if (pre_q.zero) begin
      slot_v_o = '0;
    end else if (pre_q.single) begin
      // request inside one sector
      slot_v_o[0]               = 1'b1;
      slot_o[0].piece_kind       = PIECE_PARTIAL;
      slot_o[0].disk_sector      = sec_head;
      slot_o[0].sector_total     = TOTAL_W'(1);
      slot_o[0].offset_in_sector = pre_q.r_off;
      slot_o[0].piece_bytes      = pre_q.cnt[SB_W-1:0];
      slot_o[0].last             = 1'b1;
    end else begin
      slot_v_o[0]               = pre_q.head_mis;
      slot_o[0].piece_kind       = PIECE_PARTIAL;
      slot_o[0].disk_sector      = sec_head;
      slot_o[0].sector_total     = TOTAL_W'(1);
      slot_o[0].offset_in_sector = pre_q.r_off;
      slot_o[0].piece_bytes      = pre_q.head_bytes;
      slot_o[0].last             = ~pre_q.has_full & ~pre_q.tail_mis;

      slot_v_o[1]            = pre_q.has_full;
      slot_o[1].piece_kind    = PIECE_FULL;
      slot_o[1].disk_sector   = sec_full;
      slot_o[1].sector_total  = pre_q.full;
      slot_o[1].buffer_offset = BYTE_W'(pre_q.head_bytes);
      slot_o[1].last          = ~pre_q.tail_mis;

      // tail data sits at the end of the caller buffer
      slot_v_o[2]               = pre_q.tail_mis;
      slot_o[2].piece_kind       = PIECE_PARTIAL;
      slot_o[2].disk_sector      = sec_tail;
      slot_o[2].sector_total     = TOTAL_W'(1);
      slot_o[2].piece_bytes      = SB_W'(pre_q.r_end);
      slot_o[2].buffer_offset    = pre_q.cnt - BYTE_W'(pre_q.r_end);
      slot_o[2].last             = 1'b1;
    end
  end

  assign load_o = pre_v_q;

endmodule

// File: hdl/sts_emit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sts_emit
// Holds the pieces of one request and shifts them out one per cycle through
// the output register.
// ----------------------------------------------------------------------------
module sts_emit import sts_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 load_i,
  input  logic [NUM_SLOTS-1:0] slot_v_i,
  input  res_t                 slot_i [NUM_SLOTS],
  output logic                 res_valid_o,
  output res_t                 res_o
);

  logic [NUM_SLOTS-1:0] slot_v_q;
  res_t                 slot_q [NUM_SLOTS];
  logic                 res_valid_q;
  res_t                 res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_v_q    <= '0;
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= slot_v_q[0];
      if (load_i) begin
        slot_v_q <= slot_v_i;
      end else begin
        slot_v_q <= {1'b0, slot_v_q[NUM_SLOTS-1:1]};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= slot_q[0];
    if (load_i) begin
      slot_q <= slot_i;
    end else begin
      for (int i = 0; i < NUM_SLOTS - 1; i++) begin
        slot_q[i] <= slot_q[i+1];
      end
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

`ifndef SYNTHESIS
  // a new request never lands on pieces still waiting to go out
  a_load_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i |-> !slot_v_q[1] && !slot_v_q[2])
    else $error("piece slots overwritten before drained");

  a_err_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_o.piece_kind == PIECE_ERROR) |-> res_o.last)
    else $error("error piece not marked last");
`endif

endmodule

// File: dv/tb_sector_transfer_splitter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sector_transfer_splitter
// Drives volume read and write requests into the sector transfer splitter,
// predicts the head, full-run, tail and error pieces for every accepted
// request and checks each piece field by field, in order, as it comes out.
// Runs a directed set under several volume settings, then random phases.
// ----------------------------------------------------------------------------
module tb_sector_transfer_splitter;
  import sts_pkg::*;

  localparam int ADDR_W      = 48;
  localparam int DRAIN_WAIT  = 80;      // covers the path from a request to its last piece
  localparam int CYCLE_LIMIT = 400000;
  localparam int PRINT_LIMIT = 100;

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 start;
  logic                 busy;
  req_t                 req_i;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [ADDR_W-1:0]    cfg_data_i;
  logic                 res_valid_o;
  res_t                 res_o;

  int unsigned cycle_count = 0;

  sector_transfer_splitter #(
    .SECTOR_ADDR_BITS(ADDR_W)
  ) u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .req_i       (req_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .res_valid_o (res_valid_o),
    .res_o       (res_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  class piece_scoreboard;
    logic [ADDR_W-1:0] vol_start;
    logic [ADDR_W-1:0] vol_sectors;
    logic [SB_W-1:0]   sec_bytes;
    res_t              pending_pieces[$];
    int unsigned       fail_count;

    function new();
      vol_start   = '0;
      vol_sectors = '0;
      sec_bytes   = SB_RESET;
      fail_count  = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [ADDR_W-1:0] data);
      case (idx)
        CFG_VOLUME_START:   vol_start   = data;
        CFG_VOLUME_SECTORS: vol_sectors = data;
        CFG_SECTOR_BYTES:   sec_bytes   = data[SB_W-1:0];
        default: ;
      endcase
    endfunction

    // sector size as the block uses it: zero counts as one, capped at 4096
    function logic [63:0] eff_sector_bytes();
      logic [63:0] v;
      v = {51'b0, sec_bytes};
      if (v == 0) v = 1;
      if (v > SB_MAX) v = 64'(SB_MAX);
      return v;
    endfunction

    function int pending_count();
      return pending_pieces.size();
    endfunction

    function res_t make_piece(piece_kind_e kind, logic wr, logic [63:0] sec,
                              logic [63:0] total, logic [63:0] ofs,
                              logic [63:0] nbytes, logic [63:0] bpos, logic fin);
      res_t p;
      p.piece_kind       = kind;
      p.is_write         = wr;
      p.disk_sector      = sec[DSEC_W-1:0];
      p.sector_total     = total[TOTAL_W-1:0];
      p.offset_in_sector = ofs[REM_W-1:0];
      p.piece_bytes      = nbytes[SB_W-1:0];
      p.buffer_offset    = bpos[BYTE_W-1:0];
      p.last             = fin;
      return p;
    endfunction

    // split one request into the pieces it should produce
    function void note_request(req_t r);
      logic [63:0] off, cnt, sbv, lim, endp, first, last_sec;
      logic [63:0] head_bytes, full, buf_pos, base;
      logic        head_mis, tail_mis, wr;
      wr   = ~r.action;
      off  = {4'b0, r.byte_offset};
      cnt  = {4'b0, r.byte_count};
      sbv  = eff_sector_bytes();
      base = {16'b0, vol_start};
      lim  = {16'b0, vol_sectors} * sbv;
      endp = off + cnt;
      // past the volume end, checked ahead of the zero count
      if (endp > lim) begin
        pending_pieces.push_back(make_piece(PIECE_ERROR, wr, 0, 0, 0, 0, 0, 1'b1));
        return;
      end
      if (cnt == 0) return;
      head_mis   = (off % sbv) != 0;
      tail_mis   = (endp % sbv) != 0;
      first      = off / sbv;
      last_sec   = endp / sbv;
      head_bytes = (first + head_mis) * sbv - off;
      full       = (cnt > head_bytes) ? (cnt - head_bytes) / sbv : 0;
      if (head_mis && tail_mis && first == last_sec) begin
        pending_pieces.push_back(make_piece(PIECE_PARTIAL, wr, base + first, 1,
                                            off % sbv, cnt, 0, 1'b1));
        return;
      end
      buf_pos = 0;
      if (head_mis) begin
        pending_pieces.push_back(make_piece(PIECE_PARTIAL, wr, base + first, 1,
                                            sbv - head_bytes, head_bytes, buf_pos,
                                            full == 0 && !tail_mis));
        buf_pos += head_bytes;
      end
      if (full != 0) begin
        pending_pieces.push_back(make_piece(PIECE_FULL, wr, base + first + head_mis,
                                            full, 0, 0, buf_pos, !tail_mis));
        buf_pos += full * sbv;
      end
      if (tail_mis) begin
        pending_pieces.push_back(make_piece(PIECE_PARTIAL, wr, base + last_sec, 1, 0,
                                            endp - last_sec * sbv, buf_pos, 1'b1));
      end
    endfunction

    task report(string msg);
      if (fail_count < PRINT_LIMIT) $display("[%0t] mismatch: %s", $realtime, msg);
      fail_count++;
    endtask

    task check_piece(res_t got);
      res_t want;
      if (pending_pieces.size() == 0) begin
        report($sformatf("piece with nothing expected, kind %0d sector %0h",
                         got.piece_kind, got.disk_sector));
        return;
      end
      want = pending_pieces.pop_front();
      if (got.piece_kind !== want.piece_kind)
        report($sformatf("piece_kind got %0d want %0d", got.piece_kind, want.piece_kind));
      if (got.is_write !== want.is_write)
        report($sformatf("is_write got %0b want %0b", got.is_write, want.is_write));
      if (got.disk_sector !== want.disk_sector)
        report($sformatf("disk_sector got %0h want %0h", got.disk_sector,
                         want.disk_sector));
      if (got.sector_total !== want.sector_total)
        report($sformatf("sector_total got %0h want %0h", got.sector_total,
                         want.sector_total));
      if (got.offset_in_sector !== want.offset_in_sector)
        report($sformatf("offset_in_sector got %0d want %0d", got.offset_in_sector,
                         want.offset_in_sector));
      if (got.piece_bytes !== want.piece_bytes)
        report($sformatf("piece_bytes got %0d want %0d", got.piece_bytes,
                         want.piece_bytes));
      if (got.buffer_offset !== want.buffer_offset)
        report($sformatf("buffer_offset got %0h want %0h", got.buffer_offset,
                         want.buffer_offset));
      if (got.last !== want.last)
        report($sformatf("last got %0b want %0b", got.last, want.last));
    endtask
  endclass

  piece_scoreboard board;

  always @(posedge clk_i) begin
    if (rst_ni && res_valid_o === 1'b1) board.check_piece(res_o);
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_sector_transfer_splitter NOT OK");
      $finish;
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic req_t mk_req(logic act, logic [63:0] off, logic [63:0] cnt);
    req_t r;
    r.action      = act;
    r.byte_offset = off[BYTE_W-1:0];
    r.byte_count  = cnt[BYTE_W-1:0];
    return r;
  endfunction

  // mostly in-range requests of every shape, the rest noise and overruns
  function automatic req_t rand_request();
    logic [63:0] sbv, vs, lim, first, k, spos, epos, tmp, off, cnt;
    logic        act;
    sbv = board.eff_sector_bytes();
    vs  = {16'b0, board.vol_sectors};
    lim = vs * sbv;
    act = 1'($urandom_range(0, 1));
    if (lim == 0 || $urandom_range(0, 99) < 18) begin
      case ($urandom_range(0, 3))
        0: begin
          off = rand64();
          cnt = rand64();
        end
        1: begin
          // one byte past the end
          off = (rand64() >> 4) % (lim + 1);
          cnt = lim - off + 1;
        end
        2: begin
          off = lim + $urandom_range(0, 3);
          cnt = 0;
        end
        default: begin
          off = (rand64() >> 4) >> $urandom_range(0, 59);
          cnt = (rand64() >> 4) >> $urandom_range(0, 59);
        end
      endcase
      return mk_req(act, off, cnt);
    end
    first = rand64() % vs;
    spos  = first * sbv + ($urandom_range(0, 1) ? 64'd0 : rand64() % sbv);
    k     = ($urandom_range(0, 19) == 0) ? rand64() % (vs - first + 1)
                                         : 64'($urandom_range(0, 4));
    epos  = (first + k) * sbv + ($urandom_range(0, 1) ? 64'd0 : rand64() % sbv);
    if (epos > lim) epos = lim;
    if (epos < spos) begin
      tmp  = epos;
      epos = spos;
      spos = tmp;
    end
    if ($urandom_range(0, 29) == 0) epos = spos;
    return mk_req(act, spos, epos - spos);
  endfunction

  task automatic send_request(req_t r);
    start <= 1'b1;
    req_i <= r;
    do @(posedge clk_i); while (busy);
    board.note_request(r);
  endtask

  task automatic maybe_idle(bit allow);
    if (allow && $urandom_range(0, 99) < 27) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
  endtask

  task automatic send_directed(logic act, logic [63:0] off, logic [63:0] cnt);
    send_request(mk_req(act, off, cnt));
    maybe_idle(1'b1);
  endtask

  // zero-count requests leave nothing to wait for, so sit out the latency too
  task automatic drain();
    start <= 1'b0;
    while (board.pending_count() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [ADDR_W-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    board.set_reg(idx, data);
  endtask

  task automatic set_volume(logic [ADDR_W-1:0] vstart, logic [ADDR_W-1:0] vsecs,
                            logic [SB_W-1:0] sbytes);
    write_reg(CFG_VOLUME_START, vstart);
    write_reg(CFG_VOLUME_SECTORS, vsecs);
    write_reg(CFG_SECTOR_BYTES, {{(ADDR_W-SB_W){1'b0}}, sbytes});
    cfg_we_i <= 1'b0;
  endtask

  task automatic random_volume();
    logic [ADDR_W-1:0] vstart, vsecs;
    logic [SB_W-1:0]   sbytes;
    case ($urandom_range(0, 3))
      0:       vsecs = ADDR_W'($urandom_range(1, 100));
      1:       vsecs = ADDR_W'($urandom_range(1, 1 << 20));
      2:       vsecs = '1;
      default: vsecs = ADDR_W'(rand64());
    endcase
    case ($urandom_range(0, 2))
      0:       vstart = '0;
      1:       vstart = '1;
      default: vstart = ADDR_W'(rand64());
    endcase
    case ($urandom_range(0, 9))
      0: sbytes = '0;
      1: sbytes = 13'd1;
      2: sbytes = SB_W'($urandom_range(2, 7));
      3: sbytes = 13'd512;
      4: sbytes = SB_W'($urandom_range(500, 520));
      5: sbytes = 13'd4095;
      6: sbytes = SB_MAX;
      7: sbytes = SB_W'($urandom_range(4097, 8191));
      default: sbytes = SB_W'($urandom_range(1, 4096));
    endcase
    set_volume(vstart, vsecs, sbytes);
  endtask

  task automatic run_random(int n, bit allow_idle);
    for (int i = 0; i < n; i++) begin
      send_request(rand_request());
      maybe_idle(allow_idle);
    end
  endtask

  initial begin
    board      = new();
    rst_ni     <= 1'b0;
    start      <= 1'b0;
    req_i      <= '0;
    cfg_we_i   <= 1'b0;
    cfg_idx_i  <= CFG_VOLUME_START;
    cfg_data_i <= '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset volume is empty: zero count at zero passes, the rest overrun
    send_directed(1'b0, 0, 0);
    send_directed(1'b1, 0, 1);
    send_directed(1'b1, 5, 0);
    drain();

    set_volume(48'd1000, 48'd64, 13'd512);
    send_directed(1'b1, 0, 512);
    send_directed(1'b0, 100, 50);
    send_directed(1'b0, 100, 1000);
    send_directed(1'b1, 100, 412);
    send_directed(1'b1, 1024, 100);
    send_directed(1'b0, 512, 2048);
    send_directed(1'b0, 300, 1236);
    send_directed(1'b1, 0, 32768);
    send_directed(1'b1, 32767, 1);
    send_directed(1'b1, 32767, 2);
    send_directed(1'b0, 32768, 0);
    send_directed(1'b1, 40000, 0);
    send_directed(1'b0, 511, 2);
    send_directed(1'b1, {4'b0, {BYTE_W{1'b1}}}, {4'b0, {BYTE_W{1'b1}}});
    drain();

    // zero sector size counts as one byte
    set_volume('1, '1, 13'd0);
    send_directed(1'b0, 0, 5);
    send_directed(1'b1, 64'hFFFF_FFFF_FFFE, 1);
    send_directed(1'b0, 64'h7FFF_FFFF_FFF0, 64'h10);
    drain();

    // oversized sector size caps at 4096
    set_volume(48'd7, '1, 13'd8191);
    send_directed(1'b1, 64'h0FFF_FFFF_FFFF_F000 - 5000, 5000);
    send_directed(1'b0, 4095, 1);
    send_directed(1'b1, 1, 4095);
    send_directed(1'b0, 0, 4096);
    drain();

    set_volume('0, 48'd1, SB_MAX);
    send_directed(1'b1, 0, 4096);
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      random_volume();
      run_random(58, ph != 2);
      drain();
    end

    if (board.fail_count == 0 && board.pending_count() == 0) begin
      $display("tb_sector_transfer_splitter OK");
    end else begin
      $display("tb_sector_transfer_splitter NOT OK");
    end
    $finish;
  end

endmodule

// File: sim.f
hdl/sts_pkg.sv
hdl/sts_div_cell.sv
hdl/sts_piece_build.sv
hdl/sts_emit.sv
hdl/sector_transfer_splitter.sv
dv/tb_sector_transfer_splitter.sv
